// File: rtl/core/xrrg_pkg.sv
package xrrg_pkg;

	localparam int unsigned WordW = 64;
	localparam int unsigned FracW = 53;
	localparam int unsigned FracLsb = WordW - FracW;
	localparam int unsigned HalfW = WordW / 2;
	localparam int unsigned InDataW = 2 * WordW;
	localparam int unsigned OutDataW = ((WordW + FracW + 7) / 8) * 8;
	localparam int unsigned DivCntW = $clog2(WordW);

	localparam logic [WordW-1:0] GoldenWord = 64'h9e3779b97f4a7c15;
	localparam logic [WordW-1:0] ScrambleMul = 64'h2545f4914f6cdd1d;

	localparam int unsigned ShiftA = 12;
	localparam int unsigned ShiftB = 25;
	localparam int unsigned ShiftC = 27;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic advance;
		logic mul_step;
		logic div_step;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_in;
		logic mul_last;
		logic div_last;
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_ADV  = 5'b00010,
		ST_MUL  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

endpackage

// File: rtl/core/xrrg_ctrl.sv
module xrrg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  xrrg_pkg::status_t status,
	output xrrg_pkg::cmd_t    cmd
);

	xrrg_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic accept;
	logic out_free;

	assign s_tready = (state_q == xrrg_pkg::ST_IDLE);
	assign accept = s_tvalid & s_tready;
	assign out_free = ~out_valid_q | m_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			xrrg_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.start = 1'b1;
					state_d = status.bad_in ? xrrg_pkg::ST_DONE : xrrg_pkg::ST_ADV;
				end
			end
			xrrg_pkg::ST_ADV: begin
				cmd.advance = 1'b1;
				state_d = xrrg_pkg::ST_MUL;
			end
			xrrg_pkg::ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (status.mul_last) begin
					state_d = xrrg_pkg::ST_DIV;
				end
			end
			xrrg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = xrrg_pkg::ST_DONE;
				end
			end
			xrrg_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d = xrrg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = xrrg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xrrg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/xrrg_dp.sv
module xrrg_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [xrrg_pkg::WordW-1:0]           cfg_data,
	input  logic [xrrg_pkg::WordW-1:0]           range_low,
	input  logic [xrrg_pkg::WordW-1:0]           range_high,
	input  xrrg_pkg::cmd_t                       cmd,
	output xrrg_pkg::status_t                    status,
	output logic [xrrg_pkg::WordW-1:0]           ranged_value,
	output logic [xrrg_pkg::FracW-1:0]           unit_fraction,
	output logic                                 bad_range
);

	localparam int unsigned W = xrrg_pkg::WordW;
	localparam int unsigned H = xrrg_pkg::HalfW;

	logic [W-1:0] gen_q;
	logic [W-1:0] gen_adv;
	logic [W-1:0] lo_q;
	logic [W-1:0] span_q;
	logic         span_zero_q;
	logic         err_q;
	logic [1:0]   mul_cnt_q;
	logic [W-1:0] prod_q;
	logic [W-1:0] acc_q;
	logic [W-1:0] acc_next;
	logic [H-1:0] mul_a;
	logic [H-1:0] mul_b;
	logic [W-1:0] quo_q;
	logic [W:0]   rem_q;
	logic [W:0]   rem_sh;
	logic [xrrg_pkg::DivCntW-1:0] div_cnt_q;
	logic [W-1:0] span_in;
	logic [W-1:0] offset;
	logic [W-1:0] t1;
	logic [W-1:0] t2;
	logic [W-1:0] value_q;
	logic [xrrg_pkg::FracW-1:0] frac_q;
	logic         bad_q;

	// signed lo > hi
	assign status.bad_in = $signed(range_low) > $signed(range_high);
	assign status.mul_last = (mul_cnt_q == 2'd3);
	assign status.div_last = (div_cnt_q == {xrrg_pkg::DivCntW{1'b1}});

	assign span_in = range_high - range_low + {{(W-1){1'b0}}, 1'b1};

	assign t1 = gen_q ^ (gen_q >> xrrg_pkg::ShiftA);
	assign t2 = t1 ^ (t1 << xrrg_pkg::ShiftB);
	assign gen_adv = t2 ^ (t2 >> xrrg_pkg::ShiftC);

	// product mod 2^64 from three 32x32 partial products
	always_comb begin
		case (mul_cnt_q)
			2'd0: begin
				mul_a = gen_q[H-1:0];
				mul_b = xrrg_pkg::ScrambleMul[H-1:0];
			end
			2'd1: begin
				mul_a = gen_q[H-1:0];
				mul_b = xrrg_pkg::ScrambleMul[W-1:H];
			end
			default: begin
				mul_a = gen_q[W-1:H];
				mul_b = xrrg_pkg::ScrambleMul[H-1:0];
			end
		endcase
	end

	always_comb begin
		case (mul_cnt_q)
			2'd0: acc_next = acc_q;
			2'd1: acc_next = prod_q;
			default: acc_next = acc_q + {prod_q[H-1:0], {H{1'b0}}};
		endcase
	end

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= xrrg_pkg::GoldenWord;
		end else if (cfg_valid) begin
			gen_q <= (cfg_data == '0) ? xrrg_pkg::GoldenWord : cfg_data;
		end else if (cmd.advance) begin
			gen_q <= gen_adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_cnt_q <= 2'd0;
			div_cnt_q <= '0;
		end else begin
			if (cmd.advance) begin
				mul_cnt_q <= 2'd0;
			end else if (cmd.mul_step) begin
				mul_cnt_q <= mul_cnt_q + 2'd1;
			end
			if (cmd.mul_step) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + {{(xrrg_pkg::DivCntW-1){1'b0}}, 1'b1};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			lo_q <= range_low;
			span_q <= span_in;
			span_zero_q <= (span_in == '0);
			err_q <= status.bad_in;
		end
		if (cmd.mul_step) begin
			prod_q <= {{H{1'b0}}, mul_a} * {{H{1'b0}}, mul_b};
			acc_q <= acc_next;
			if (status.mul_last) begin
				quo_q <= acc_next;
				rem_q <= '0;
			end
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[W-2:0], 1'b0};
			if (rem_sh >= {1'b0, span_q}) begin
				rem_q <= rem_sh - {1'b0, span_q};
			end else begin
				rem_q <= rem_sh;
			end
		end
	end

	assign offset = span_zero_q ? acc_q : rem_q[W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			value_q <= err_q ? '0 : lo_q + offset;
			frac_q <= err_q ? '0 : acc_q[W-1:xrrg_pkg::FracLsb];
			bad_q <= err_q;
		end
	end

	assign ranged_value = value_q;
	assign unit_fraction = frac_q;
	assign bad_range = bad_q;

endmodule

// File: rtl/core/xorshift_range_random_generator_unit.sv
// xorshift64* ranged random generator.
// s_axis: one request per item, tdata = {range_high, range_low}.
// m_axis: one result per request, tdata = ranged_value and unit_fraction,
//   tuser = bad_range (lo > hi: zeros out, generator word not advanced).
// cfg: a write of cfg_data reseeds the generator word (zero loads the golden
//   constant). cfg_ready is always high; write only while the block is idle.
// Flow: a valid request runs through the xorshift step, the shared 32x32
//   multiplier partial products, the bit-serial remainder unit and the load
//   of the output register. A bad range goes straight to the output
//   register. One request is worked on at a time; the next is accepted once
//   the result sits in the output register.
// Reset: generator word loads 0x9e3779b97f4a7c15, no result pending.
// Stall: the result holds in the output register while m_tready is low;
//   a finished result waits in the controller until that register frees up.
module xorshift_range_random_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [63:0] range_low, [127:64] range_high
	input  logic [xrrg_pkg::InDataW-1:0]        s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [63:0] ranged_value, [116:64] unit_fraction, rest zero
	output logic [xrrg_pkg::OutDataW-1:0]       m_tdata,
	// [0] bad_range
	output logic                                m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [xrrg_pkg::WordW-1:0]          cfg_data
);

	xrrg_pkg::cmd_t    cmd;
	xrrg_pkg::status_t status;
	logic [xrrg_pkg::WordW-1:0] ranged_value;
	logic [xrrg_pkg::FracW-1:0] unit_fraction;

	assign cfg_ready = 1'b1;

	xrrg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	xrrg_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (cfg_data),
		.range_low     (s_tdata[xrrg_pkg::WordW-1:0]),
		.range_high    (s_tdata[xrrg_pkg::InDataW-1:xrrg_pkg::WordW]),
		.cmd           (cmd),
		.status        (status),
		.ranged_value  (ranged_value),
		.unit_fraction (unit_fraction),
		.bad_range     (m_tuser)
	);

	assign m_tdata = {{(xrrg_pkg::OutDataW - xrrg_pkg::WordW - xrrg_pkg::FracW){1'b0}},
		unit_fraction, ranged_value};

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int unsigned WordW = xrrg_pkg::WordW;
	localparam int unsigned FracW = xrrg_pkg::FracW;
	localparam int unsigned FracLsb = xrrg_pkg::FracLsb;
	localparam int unsigned InDataW = xrrg_pkg::InDataW;
	localparam int unsigned OutDataW = xrrg_pkg::OutDataW;
	localparam int unsigned ShiftA = xrrg_pkg::ShiftA;
	localparam int unsigned ShiftB = xrrg_pkg::ShiftB;
	localparam int unsigned ShiftC = xrrg_pkg::ShiftC;
	localparam logic [WordW-1:0] GoldenWord = xrrg_pkg::GoldenWord;
	localparam logic [WordW-1:0] ScrambleMul = xrrg_pkg::ScrambleMul;

	localparam logic [WordW-1:0] MaxS = 64'h7fff_ffff_ffff_ffff;
	localparam logic [WordW-1:0] MinS = 64'h8000_0000_0000_0000;
	localparam logic [WordW-1:0] AllOnes = 64'hffff_ffff_ffff_ffff;
	localparam int unsigned NumPhases = 7;
	localparam int unsigned RandPerPhase = 115;
	localparam int unsigned DrainCycles = 90;
	localparam int unsigned CycleLimit = 1_000_000;

	// idle styles for either side
	localparam int unsigned IdleNone = 0;
	localparam int unsigned IdleFull = 1;
	localparam int unsigned IdleRare = 2;

	typedef struct packed {
		logic [WordW-1:0] lo;
		logic [WordW-1:0] hi;
	} range_req_t;

	typedef struct packed {
		logic [WordW-1:0] value;
		logic [FracW-1:0] frac;
		logic             bad;
	} range_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OutDataW-1:0] m_tdata;
	logic                m_tuser;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [WordW-1:0]    cfg_data = '0;

	// predictor state
	logic [WordW-1:0] gen_word = GoldenWord;

	range_req_t    request_q[$];
	range_result_t expected_q[$];
	range_req_t    cur_req;
	range_result_t got_res;
	range_result_t want_res;

	int unsigned src_idle = IdleNone;
	int unsigned snk_idle = IdleNone;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	xorshift_range_random_generator_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	// advances the generator word for a good range, then reduces the scrambled draw
	function automatic range_result_t next_range_result(logic [WordW-1:0] lo,
			logic [WordW-1:0] hi);
		range_result_t r;
		logic [WordW-1:0] w;
		logic [WordW-1:0] draw;
		logic [WordW-1:0] span;
		logic [WordW-1:0] offset;
		r = '0;
		if ($signed(lo) > $signed(hi)) begin
			r.bad = 1'b1;
		end else begin
			w = gen_word;
			w = w ^ (w >> ShiftA);
			w = w ^ (w << ShiftB);
			w = w ^ (w >> ShiftC);
			gen_word = w;
			draw = w * ScrambleMul;
			span = hi - lo + 64'd1;
			// span of zero means the bounds cover all 2^64 values
			offset = (span == '0) ? draw : draw % span;
			r.value = lo + offset;
			r.frac = draw[WordW-1:FracLsb];
		end
		return r;
	endfunction

	function automatic int unsigned draw_wait(int unsigned style);
		if (style == IdleFull)
			return $urandom_range(0, 16);
		if (style == IdleRare)
			return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
		return 0;
	endfunction

	// wide value, often sign-shifted down to a small magnitude
	function automatic logic [WordW-1:0] rand_word();
		logic [WordW-1:0] w;
		w = {$urandom, $urandom};
		if ($urandom_range(0, 1) == 1)
			w = $unsigned($signed(w) >>> $urandom_range(0, 62));
		return w;
	endfunction

	function automatic range_req_t make_random_request();
		range_req_t r;
		logic [WordW-1:0] a;
		logic [WordW-1:0] b;
		logic [WordW-1:0] width;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		a = rand_word();
		b = rand_word();
		if (pick < 12) begin
			// inverted bounds
			if (a == b) begin
				r.lo = 64'd1;
				r.hi = 64'd0;
			end else if ($signed(a) > $signed(b)) begin
				r.lo = a;
				r.hi = b;
			end else begin
				r.lo = b;
				r.hi = a;
			end
		end else if (pick < 27) begin
			// list choice of count entries, count zero gives an empty list
			r.lo = '0;
			r.hi = 64'($urandom_range(0, 1000)) - 64'd1;
		end else if (pick < 60) begin
			width = 64'($urandom_range(0, 1 << $urandom_range(0, 20)));
			r.lo = a;
			r.hi = a + width;
			if ($signed(r.hi) < $signed(r.lo)) begin
				r.hi = MaxS;
				r.lo = MaxS - width;
			end
		end else if (pick < 95) begin
			if ($signed(a) > $signed(b)) begin
				r.lo = b;
				r.hi = a;
			end else begin
				r.lo = a;
				r.hi = b;
			end
		end else begin
			// full or nearly full span
			r.lo = MinS + 64'($urandom_range(0, 3));
			r.hi = MaxS - 64'($urandom_range(0, 3));
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [WordW-1:0] got,
			input logic [WordW-1:0] want);
		error_count++;
		$display("[%0t] %s: got %h want %h", $time, what, got, want);
	endtask

	task automatic queue_request(input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
		range_req_t r;
		r.lo = lo;
		r.hi = hi;
		request_q.push_back(r);
	endtask

	// sampled at the falling edge so that all updates of the rising edge are in
	task automatic wait_drained();
		do
			@(negedge clk);
		while (request_q.size() != 0 || s_tvalid || expected_q.size() != 0);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_seed(input logic [WordW-1:0] seed);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= seed;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		gen_word = (seed == '0) ? GoldenWord : seed;
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_q.push_back(next_range_result(s_tdata[WordW-1:0],
					s_tdata[InDataW-1:WordW]));
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap--;
				end else if (request_q.size() > 0) begin
					cur_req = request_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_req.hi, cur_req.lo};
					send_gap = draw_wait(src_idle);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_res.value = m_tdata[WordW-1:0];
				got_res.frac = m_tdata[WordW+FracW-1:WordW];
				got_res.bad = m_tuser;
				if (expected_q.size() == 0) begin
					report_mismatch("result with no request pending", got_res.value, '0);
				end else begin
					want_res = expected_q.pop_front();
					if (got_res.value !== want_res.value)
						report_mismatch("ranged_value", got_res.value, want_res.value);
					if (got_res.frac !== want_res.frac)
						report_mismatch("unit_fraction", 64'(got_res.frac),
							64'(want_res.frac));
					if (got_res.bad !== want_res.bad)
						report_mismatch("bad_range", 64'(got_res.bad), 64'(want_res.bad));
					if (m_tdata[OutDataW-1:WordW+FracW] !== '0)
						report_mismatch("tdata pad bits",
							64'(m_tdata[OutDataW-1:WordW+FracW]), '0);
				end
				recv_stall = draw_wait(snk_idle);
			end
			if (recv_stall > 0) begin
				m_tready <= 1'b0;
				recv_stall--;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		gen_word = GoldenWord;

		for (int p = 0; p < NumPhases; p++) begin
			if (p > 0) begin
				case (p)
					1: write_seed('0);
					2: write_seed(AllOnes);
					3: write_seed(64'd1);
					5: write_seed(MinS);
					default: write_seed({$urandom, $urandom});
				endcase
			end
			case (p % 4)
				0: begin src_idle = IdleNone; snk_idle = IdleNone; end
				1: begin src_idle = IdleFull; snk_idle = IdleFull; end
				2: begin src_idle = IdleRare; snk_idle = IdleFull; end
				default: begin src_idle = IdleFull; snk_idle = IdleRare; end
			endcase
			if (p == 0) begin
				queue_request('0, '0);
				queue_request(MinS, MaxS);
				queue_request(MaxS, MaxS);
				queue_request(MinS, MinS);
				queue_request('0, AllOnes);
				queue_request(MaxS, MinS);
				queue_request(64'd1, '0);
				queue_request(AllOnes, AllOnes);
				queue_request('0, 64'd9);
				queue_request(-64'sd5, 64'sd5);
				queue_request(MinS, '0);
				queue_request('0, MaxS);
				queue_request(AllOnes, '0);
				queue_request(MinS + 64'd1, MaxS);
				queue_request(MinS, MaxS - 64'd1);
				queue_request('0, 64'h0000_0000_ffff_ffff);
				queue_request(AllOnes, MaxS);
				queue_request(MinS, AllOnes);
				queue_request(MinS, MaxS);
			end
			for (int i = 0; i < RandPerPhase; i++)
				request_q.push_back(make_random_request());
			// hold back the next phase until every result is in
			wait_drained();
		end

		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/core/xrrg_pkg.sv
rtl/core/xrrg_ctrl.sv
rtl/core/xrrg_dp.sv
rtl/core/xorshift_range_random_generator_unit.sv
verif/tb.sv
